// ===== src/qte_pkg.sv =====
// Shared constants, types and helper functions for the quaternion to Euler angle converter.
package qte_pkg;

    // Number of CORDIC rotation cells per angle lane (8 to 24).
    localparam int CORDIC_STAGES = 16;

    // Square root cells: one result bit per cell, root of a value up to 2^56.
    localparam int SQRT_STAGES = 29;
    localparam int ROOT_W      = 29;
    localparam int REM_W       = 57;

    localparam int FRAC_BITS = 28;
    localparam int CW        = 37;   // CORDIC x and y datapath width
    localparam int AW        = 34;   // angle accumulator width, radians * 2^30
    localparam int SHW       = 5;    // shift / stage index width
    localparam int PW        = 33;   // width of w*x - y*z
    localparam int MAG_W     = 28;   // magnitude of 2*pitch when not clamped
    localparam int DEG_W     = 27;
    localparam int PROD_W    = AW + DEG_W;
    localparam int SAT_W     = 20;

    // Stages from the input register to the final rounding register.
    localparam int PIPE_LEN = 4 + SQRT_STAGES + 1 + CORDIC_STAGES + 2;

    localparam logic signed [PW-1:0] PITCH_LIMIT     = 33'sd134217594;
    localparam logic signed [PW-1:0] NEG_PITCH_LIMIT = -33'sd134217594;
    localparam logic signed [AW-1:0] PI_Q30          = 34'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30     = 34'sd1686629713;
    localparam logic signed [DEG_W-1:0] DEG_FACTOR   = 27'sd60078979;
    localparam logic signed [CW-1:0] ONE_Q28         = CW'(2 ** FRAC_BITS);

    // One vector on its way through a CORDIC lane.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_vec;

    // Data that travels beside the square root cells.
    typedef struct packed {
        logic signed [CW-1:0] zn;
        logic signed [CW-1:0] zd;
        logic signed [CW-1:0] yn;
        logic signed [CW-1:0] yd;
        logic signed [CW-1:0] s;
        logic                 clamp;
        logic                 neg;
    } t_side;

    // Gimbal lock flags that travel beside the CORDIC cells.
    typedef struct packed {
        logic clamp;
        logic neg;
    } t_flags;

    // One finished result.
    typedef struct packed {
        logic signed [15:0] ang_z;
        logic signed [15:0] ang_x;
        logic signed [15:0] ang_y;
        logic               clamp;
    } t_res;

    // Elementary angles atan(2^-i) in radians scaled by 2^30.
    function automatic logic signed [AW-1:0] atan_q30(input logic [SHW-1:0] idx);
        logic signed [AW-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Folds a left half plane vector into the right half plane and seeds the angle.
    function automatic t_vec cordic_pre(input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] x);
        t_vec v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.ang  = '0;
        if (x[CW-1]) begin
            v.x   = -x;
            v.y   = -y;
            v.ang = y[CW-1] ? -PI_Q30 : PI_Q30;
        end
        return v;
    endfunction

    // Saturates a rounded angle to the 16 bit output range.
    function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -(SAT_W'(32768))) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== src/qte_sqrt_cell.sv =====
// One cell of the pipelined square root: settles one bit of the root.
module qte_sqrt_cell (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qte_pkg::SHW-1:0]         i_bit,
    input  logic [qte_pkg::REM_W-1:0]       i_rem,
    input  logic [qte_pkg::ROOT_W-1:0]      i_root,
    output logic [qte_pkg::REM_W-1:0]       o_rem,
    output logic [qte_pkg::ROOT_W-1:0]      o_root
);

    logic [qte_pkg::REM_W:0]        d;
    logic [qte_pkg::REM_W:0]        rem_x;
    logic [qte_pkg::REM_W:0]        diff;
    logic [qte_pkg::REM_W-1:0]      n_rem;
    logic [qte_pkg::ROOT_W-1:0]     n_root;
    logic [qte_pkg::REM_W-1:0]      r_rem;
    logic [qte_pkg::ROOT_W-1:0]     r_root;

    // The trial term is (2*root + 2^bit) * 2^bit, taken from the remainder if it fits.
    always_comb begin
        d      = ((qte_pkg::REM_W + 1)'(i_root) << (i_bit + 1))
               + ((qte_pkg::REM_W + 1)'(1) << (2 * i_bit));
        rem_x  = {1'b0, i_rem};
        diff   = rem_x - d;
        n_rem  = i_rem;
        n_root = i_root;
        if (rem_x >= d) begin
            n_rem  = diff[qte_pkg::REM_W-1:0];
            n_root = i_root | (qte_pkg::ROOT_W'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== src/qte_cordic_cell.sv =====
// One vectoring CORDIC rotation cell with its angle accumulator.
module qte_cordic_cell (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [qte_pkg::SHW-1:0] i_shift,
    input  qte_pkg::t_vec           i_vec,
    output qte_pkg::t_vec           o_vec
);

    logic signed [qte_pkg::CW-1:0] dx;
    logic signed [qte_pkg::CW-1:0] dy;
    qte_pkg::t_vec                 n_vec;
    qte_pkg::t_vec                 r_vec;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        dx    = i_vec.y >>> i_shift;
        dy    = i_vec.x >>> i_shift;
        n_vec = i_vec;
        if (!i_vec.y[qte_pkg::CW-1]) begin
            n_vec.x   = i_vec.x + dx;
            n_vec.y   = i_vec.y - dy;
            n_vec.ang = i_vec.ang + qte_pkg::atan_q30(i_shift);
        end else begin
            n_vec.x   = i_vec.x - dx;
            n_vec.y   = i_vec.y + dy;
            n_vec.ang = i_vec.ang - qte_pkg::atan_q30(i_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

// ===== src/quaternion_to_euler.sv =====
// Top level: quaternion to Euler angle converter with a pipelined root and CORDIC chain.
// A transaction passes the input register, the product, term and square stages, the 29 square
// root cells, the fold stage, the 16 CORDIC cells and scale stages A and B to the output register.
// Throughput: one transaction per cycle while the skid register is empty; every stage is a
// register that moves whenever the pipe is enabled, and the pipe stalls while the skid is full.
// A one-entry skid register behind the output register catches the next result while one waits.
// Reset (synchronous, active low) empties the pipeline and the output and selects radians.
module quaternion_to_euler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_angle_about_z,
    output logic signed [15:0] o_angle_about_x,
    output logic signed [15:0] o_angle_about_y,
    output logic               o_gimbal_clamped
);

    localparam int NC = qte_pkg::CORDIC_STAGES;
    localparam int NS = qte_pkg::SQRT_STAGES;
    localparam int CW = qte_pkg::CW;
    localparam int AW = qte_pkg::AW;
    localparam logic signed [15:0] RAD_HALF_PI = 16'sd12868;

    // Output scale register: 0 selects radians Q2.13, 1 selects degrees Q8.7.
    logic r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_deg <= i_cfg_wr_data;
        end
    end

    // The whole pipe moves together whenever the skid register is empty. Since the skid
    // register only fills when the output register is held, one extra result can always
    // be caught there, so this enable comes straight from a flop.
    logic                          adv;
    logic [qte_pkg::PIPE_LEN-1:0]  r_vld;
    logic                          r_out_valid;
    logic                          r_skid_valid;

    assign adv     = !r_skid_valid;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[qte_pkg::PIPE_LEN-2:0], i_valid};
        end
    end

    // Stage 0: capture the quaternion.
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qw <= i_quat_w;
            r_qx <= i_quat_x;
            r_qy <= i_quat_y;
            r_qz <= i_quat_z;
        end
    end

    // Stage 1: all nine Q3.28 products, one 16x16 multiplier each.
    logic signed [31:0] r_p_wz, r_p_xy, r_p_zz, r_p_xx, r_p_wy, r_p_xz, r_p_yy, r_p_wx, r_p_yz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_wz <= r_qw * r_qz;
            r_p_xy <= r_qx * r_qy;
            r_p_zz <= r_qz * r_qz;
            r_p_xx <= r_qx * r_qx;
            r_p_wy <= r_qw * r_qy;
            r_p_xz <= r_qx * r_qz;
            r_p_yy <= r_qy * r_qy;
            r_p_wx <= r_qw * r_qx;
            r_p_yz <= r_qy * r_qz;
        end
    end

    // Stage 2: numerators and denominators of both atan2 terms, and the gimbal lock test.
    // The lock test is made on the exact product difference w*x - y*z.
    logic signed [qte_pkg::PW-1:0]  pitch;
    logic signed [CW-1:0]           s_full;
    logic signed [CW-1:0]           s_abs;
    qte_pkg::t_side                 n_side2;
    logic [qte_pkg::MAG_W-1:0]      n_mag;
    qte_pkg::t_side                 r_side2;
    logic [qte_pkg::MAG_W-1:0]      r_mag;

    always_comb begin
        pitch         = qte_pkg::PW'(r_p_wx) - qte_pkg::PW'(r_p_yz);
        s_full        = CW'(pitch) <<< 1;
        s_abs         = s_full[CW-1] ? -s_full : s_full;
        n_side2.zn    = (CW'(r_p_wz) + CW'(r_p_xy)) <<< 1;
        n_side2.zd    = qte_pkg::ONE_Q28 - ((CW'(r_p_zz) + CW'(r_p_xx)) <<< 1);
        n_side2.yn    = (CW'(r_p_wy) + CW'(r_p_xz)) <<< 1;
        n_side2.yd    = qte_pkg::ONE_Q28 - ((CW'(r_p_xx) + CW'(r_p_yy)) <<< 1);
        n_side2.s     = s_full;
        n_side2.clamp = (pitch > qte_pkg::PITCH_LIMIT) || (pitch < qte_pkg::NEG_PITCH_LIMIT);
        n_side2.neg   = pitch[qte_pkg::PW-1];
        // When the angle is clamped the root is never used, so feed it zero.
        n_mag         = n_side2.clamp ? '0 : s_abs[qte_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side2 <= n_side2;
            r_mag   <= n_mag;
        end
    end

    // Stage 3: square of the sine term, for the cosine c = sqrt(2^56 - s*s).
    logic [2*qte_pkg::MAG_W-1:0] r_msq;
    qte_pkg::t_side              r_side3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_msq   <= r_mag * r_mag;
            r_side3 <= r_side2;
        end
    end

    // Square root chain: each cell settles one root bit, most significant first.
    logic [qte_pkg::REM_W-1:0]  sq_rem  [NS+1];
    logic [qte_pkg::ROOT_W-1:0] sq_root [NS+1];
    qte_pkg::t_side             r_sside [NS];

    assign sq_rem[0]  = {1'b1, {(qte_pkg::REM_W-1){1'b0}}} - qte_pkg::REM_W'(r_msq);
    assign sq_root[0] = '0;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_bit  (qte_pkg::SHW'(NS - 1 - k)),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sside[0] <= r_side3;
            for (int k = 1; k < NS; k++) begin
                r_sside[k] <= r_sside[k-1];
            end
        end
    end

    // Fold stage: bring each vector into the right half plane before rotation.
    qte_pkg::t_vec  r_pre_z, r_pre_x, r_pre_y;
    qte_pkg::t_flags r_pre_flags;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pre_z     <= qte_pkg::cordic_pre(r_sside[NS-1].zn, r_sside[NS-1].zd);
            r_pre_x     <= qte_pkg::cordic_pre(r_sside[NS-1].s, CW'(sq_root[NS]));
            r_pre_y     <= qte_pkg::cordic_pre(r_sside[NS-1].yn, r_sside[NS-1].yd);
            r_pre_flags <= {r_sside[NS-1].clamp, r_sside[NS-1].neg};
        end
    end

    // Three CORDIC lanes, one cell per iteration, with the lock flags riding alongside.
    qte_pkg::t_vec   vz [NC+1];
    qte_pkg::t_vec   vx [NC+1];
    qte_pkg::t_vec   vy [NC+1];
    qte_pkg::t_flags r_cflags [NC];

    assign vz[0] = r_pre_z;
    assign vx[0] = r_pre_x;
    assign vy[0] = r_pre_y;

    for (genvar i = 0; i < NC; i++) begin : g_cordic
        qte_cordic_cell u_z (
            .i_clk(i_clk), .i_en(adv), .i_shift(qte_pkg::SHW'(i)), .i_vec(vz[i]), .o_vec(vz[i+1])
        );
        qte_cordic_cell u_x (
            .i_clk(i_clk), .i_en(adv), .i_shift(qte_pkg::SHW'(i)), .i_vec(vx[i]), .o_vec(vx[i+1])
        );
        qte_cordic_cell u_y (
            .i_clk(i_clk), .i_en(adv), .i_shift(qte_pkg::SHW'(i)), .i_vec(vy[i]), .o_vec(vy[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cflags[0] <= r_pre_flags;
            for (int k = 1; k < NC; k++) begin
                r_cflags[k] <= r_cflags[k-1];
            end
        end
    end

    // Scale stage A: final angles (zero vector gives zero, gimbal lock sets x to plus or minus half pi)
    // and their products with the degree factor.
    logic signed [AW-1:0]              ang_z, ang_x, ang_y;
    logic signed [AW-1:0]              r_ang_z, r_ang_x, r_ang_y;
    logic signed [qte_pkg::PROD_W-1:0] r_prod_z, r_prod_x, r_prod_y;
    logic                              r_clamp_a;

    always_comb begin
        ang_z = vz[NC].zero ? '0 : vz[NC].ang;
        ang_y = vy[NC].zero ? '0 : vy[NC].ang;
        ang_x = vx[NC].zero ? '0 : vx[NC].ang;
        if (r_cflags[NC-1].clamp) begin
            ang_x = r_cflags[NC-1].neg ? -qte_pkg::HALF_PI_Q30 : qte_pkg::HALF_PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang_z   <= ang_z;
            r_ang_x   <= ang_x;
            r_ang_y   <= ang_y;
            r_prod_z  <= ang_z * qte_pkg::DEG_FACTOR;
            r_prod_x  <= ang_x * qte_pkg::DEG_FACTOR;
            r_prod_y  <= ang_y * qte_pkg::DEG_FACTOR;
            r_clamp_a <= r_cflags[NC-1].clamp;
        end
    end

    // Scale stage B: round half up, then saturate to 16 bits.
    function automatic logic signed [15:0] round_out(input logic signed [AW-1:0] ang,
                                                     input logic signed [qte_pkg::PROD_W-1:0] prod,
                                                     input logic deg);
        logic signed [AW:0]              ra;
        logic signed [qte_pkg::PROD_W:0] pa;
        logic signed [qte_pkg::SAT_W-1:0] v;
        ra = (AW + 1)'(ang) + (AW + 1)'(2 ** 16);
        pa = (qte_pkg::PROD_W + 1)'(prod) + ((qte_pkg::PROD_W + 1)'(1) << 42);
        // The shifted fields are signed, so they are sign extended into the saturation width.
        if (deg) begin
            v = qte_pkg::SAT_W'($signed(pa[qte_pkg::PROD_W:43]));
        end else begin
            v = qte_pkg::SAT_W'($signed(ra[AW:17]));
        end
        return qte_pkg::sat16(v);
    endfunction

    qte_pkg::t_res r_fin;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fin.ang_z <= round_out(r_ang_z, r_prod_z, r_deg);
            r_fin.ang_x <= round_out(r_ang_x, r_prod_x, r_deg);
            r_fin.ang_y <= round_out(r_ang_y, r_prod_y, r_deg);
            r_fin.clamp <= r_clamp_a;
        end
    end

    // Output register and skid register. A result leaves the pipe on every enabled cycle;
    // it goes to the output register if that is free or being taken, otherwise to the skid.
    logic         push;
    qte_pkg::t_res r_out, r_skid;

    assign push = adv && r_vld[qte_pkg::PIPE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || i_ready) begin
                r_out       <= r_fin;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= r_fin;
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_angle_about_z  = r_out.ang_z;
    assign o_angle_about_x  = r_out.ang_x;
    assign o_angle_about_y  = r_out.ang_y;
    assign o_gimbal_clamped = r_out.clamp;

    // The skid register only ever holds a result while the output register is also full.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    // A clamped x angle in radians must be exactly plus or minus half pi.
    a_clamp_half_pi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gimbal_clamped && !r_deg) |->
        (o_angle_about_x == RAD_HALF_PI || o_angle_about_x == -RAD_HALF_PI))
        else $error("clamped x angle is not half pi");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("output not empty after reset");

endmodule
